### sv/fga_pkg.sv
package fga_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int GS_W      = 7;
    localparam int FIG_W     = 6;
    localparam int GROUP_MAX = 64;
    // Sum of up to GROUP_MAX samples
    localparam int SUM_W     = SAMPLE_W + $clog2(GROUP_MAX);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUP_SIZE = 2'd0,
        CFG_FRAME_ROWS = 2'd1,
        CFG_FRAME_COLS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic                       end_of_frame;
    } t_out_beat;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [GS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

    // 0 acts as 1, anything above GROUP_MAX acts as GROUP_MAX
    function automatic logic [GS_W-1:0] clamp_group(input logic [CFG_W-1:0] v);
        logic [GS_W-1:0] res;
        if (v == '0) begin
            res = GS_W'(1);
        end else if (GS_W'(v) > GS_W'(GROUP_MAX)) begin
            res = GS_W'(GROUP_MAX);
        end else begin
            res = GS_W'(v);
        end
        return res;
    endfunction

endpackage

### sv/fga_div.sv
// Signed / unsigned restoring divider, one quotient bit per cycle.
// Result truncates toward zero and saturates to the sample range.
module fga_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fga_pkg::t_div_req i_req,
    output fga_pkg::t_div_rsp o_rsp
);

    localparam int SUM_W = fga_pkg::SUM_W;
    localparam int GS_W  = fga_pkg::GS_W;
    localparam int SW    = fga_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_quo;
    logic [GS_W-1:0]  r_rem;
    logic [GS_W-1:0]  r_dvs;

    logic [GS_W:0]    w_shift;
    logic             w_fit;
    logic [SW-1:0]    w_result;

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
                r_neg  <= i_req.dividend[SUM_W-1];
                r_quo  <= i_req.dividend[SUM_W-1] ? (~i_req.dividend + SUM_W'(1))
                                                  : i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[SUM_W-2:0], w_fit};
                r_rem <= w_fit ? GS_W'(w_shift - {1'b0, r_dvs}) : GS_W'(w_shift);
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Sign and saturate the magnitude
    always_comb begin
        if (r_neg) begin
            if (r_quo > SUM_W'(2 ** (SW - 1))) begin
                w_result = {1'b1, {(SW-1){1'b0}}};
            end else begin
                w_result = SW'(~r_quo + SUM_W'(1));
            end
        end else begin
            if (r_quo > SUM_W'(2 ** (SW - 1) - 1)) begin
                w_result = {1'b0, {(SW-1){1'b1}}};
            end else begin
                w_result = SW'(r_quo);
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = w_result;

endmodule

### sv/frame_group_averager_unit.sv
// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------------
// in       | i_in_valid   | o_in_stall   | i_in_data  (sample, last_sample)
// out      | o_out_valid  | i_out_stall  | o_out_data (mean_value, end_of_frame)
// cfg      | i_cfg_we     | -            | i_cfg_idx, i_cfg_data
//
// A sample that closes no group is accepted and read in S_IDLE, then its pixel sum
// gets a read-modify-write in the accumulator RAM in S_RMW.
// A sample on the closing frame adds the divide: S_RMW starts the bit-serial divider,
// S_DIV waits for its result, which goes to the output slot when that is free or
// waits in S_OUT until it is.
// Reset is synchronous, active low; it clears counters and the output slot and sets
// config to its defaults. The accumulator RAM is not cleared: the first frame of a group
// overwrites each entry.
// A waiting result sits in the output register, so a stall on the output only
// holds the input back once a second result is ready.
module frame_group_averager_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fga_pkg::t_in_beat               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fga_pkg::t_out_beat              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [fga_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fga_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int SW     = fga_pkg::SAMPLE_W;
    localparam int SUM_W  = fga_pkg::SUM_W;
    localparam int CFG_W  = fga_pkg::CFG_W;
    localparam int GS_W   = fga_pkg::GS_W;
    localparam int FIG_W  = fga_pkg::FIG_W;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    // compare widths: hold the clamped limits and counter + 1
    localparam int RC_W   = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;
    localparam int CC_W   = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    // config
    logic [CFG_W-1:0] r_group_size;
    logic [CFG_W-1:0] r_frame_rows;
    logic [CFG_W-1:0] r_frame_cols;

    // position counters
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [FIG_W-1:0] r_fig;

    // per-beat context held across the RMW and divide
    logic [SW-1:0]     r_sample;
    logic              r_fig0;
    logic              r_emit;
    logic              r_eof;
    logic [ADDR_W-1:0] r_addr;

    // accumulator RAM
    logic [SUM_W-1:0]  r_sums [DEPTH];
    logic [SUM_W-1:0]  r_rd_data;

    logic               r_out_valid;
    fga_pkg::t_out_beat r_out_data;

    logic [RC_W-1:0]   w_nr;
    logic [CC_W-1:0]   w_nc;
    logic [GS_W-1:0]   w_gs;
    logic [ROW_W-1:0]  w_r;
    logic [COL_W-1:0]  w_c;
    logic [RC_W-1:0]   w_r_inc;
    logic [CC_W-1:0]   w_c_inc;
    logic [ADDR_W-1:0] w_addr;
    logic              w_emit;
    logic              w_eof;
    logic              w_accept;
    logic              w_out_free;
    logic              w_out_load;
    logic [SUM_W-1:0]  w_sext;
    logic [SUM_W-1:0]  w_sum;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [FIG_W-1:0]  n_fig;

    fga_pkg::t_div_req w_div_req;
    fga_pkg::t_div_rsp w_div_rsp;

    // Clamp frame size: 0 acts as 1, oversize acts as the array bound
    always_comb begin
        if (r_frame_rows == '0) begin
            w_nr = RC_W'(1);
        end else if (RC_W'(r_frame_rows) > RC_W'(MAX_ROWS)) begin
            w_nr = RC_W'(MAX_ROWS);
        end else begin
            w_nr = RC_W'(r_frame_rows);
        end
        if (r_frame_cols == '0) begin
            w_nc = CC_W'(1);
        end else if (CC_W'(r_frame_cols) > CC_W'(MAX_COLS)) begin
            w_nc = CC_W'(MAX_COLS);
        end else begin
            w_nc = CC_W'(r_frame_cols);
        end
    end

    assign w_gs = fga_pkg::clamp_group(r_group_size);

    // A counter left past a shrunken limit restarts at zero
    assign w_r     = (RC_W'(r_row) < w_nr) ? r_row : '0;
    assign w_c     = (CC_W'(r_col) < w_nc) ? r_col : '0;
    assign w_r_inc = RC_W'(w_r) + RC_W'(1);
    assign w_c_inc = CC_W'(w_c) + CC_W'(1);
    assign w_addr  = ADDR_W'(w_r) * ADDR_W'(MAX_COLS) + ADDR_W'(w_c);

    // Closing frame: fig reached gs-1 (or beyond, after gs shrank)
    assign w_emit = (GS_W'(r_fig) + GS_W'(1)) >= w_gs;
    assign w_eof  = (w_r_inc == w_nr) && (w_c_inc == w_nc);

    // Raster advance; last_sample restarts the volume
    always_comb begin
        n_row = w_r;
        n_col = '0;
        n_fig = r_fig;
        if (i_in_data.last_sample) begin
            n_row = '0;
            n_fig = '0;
        end else if (w_c_inc >= w_nc) begin
            if (w_r_inc >= w_nr) begin
                n_row = '0;
                n_fig = w_emit ? '0 : FIG_W'(r_fig + FIG_W'(1));
            end else begin
                n_row = ROW_W'(w_r_inc);
            end
        end else begin
            n_col = COL_W'(w_c_inc);
        end
    end

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    // quotient moves into the output slot
    assign w_out_load = ((r_state == S_DIV && w_div_rsp.done) || r_state == S_OUT) &&
                        w_out_free;

    // First frame of a group overwrites; later frames accumulate
    assign w_sext = {{(SUM_W-SW){r_sample[SW-1]}}, r_sample};
    assign w_sum  = r_fig0 ? w_sext : (r_rd_data + w_sext);

    assign w_div_req.start    = (r_state == S_RMW) && r_emit;
    assign w_div_req.dividend = w_sum;
    assign w_div_req.divisor  = w_gs;

    fga_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Accumulator RAM: read every cycle at the incoming pixel, write in RMW.
    // One beat in flight, so read and write never overlap on one entry.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RMW) begin
            r_sums[r_addr] <= w_sum;
        end
        r_rd_data <= r_sums[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_group_size <= CFG_W'(1);
            r_frame_rows <= CFG_W'(64);
            r_frame_cols <= CFG_W'(64);
            r_row        <= '0;
            r_col        <= '0;
            r_fig        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fga_pkg::CFG_GROUP_SIZE: r_group_size <= i_cfg_data;
                    fga_pkg::CFG_FRAME_ROWS: r_frame_rows <= i_cfg_data;
                    fga_pkg::CFG_FRAME_COLS: r_frame_cols <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= '{mean_value:   w_div_rsp.quotient,
                                 end_of_frame: r_eof};
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sample <= i_in_data.sample;
                        r_fig0   <= (r_fig == '0);
                        r_emit   <= w_emit;
                        r_eof    <= w_eof;
                        r_addr   <= w_addr;
                        r_row    <= n_row;
                        r_col    <= n_col;
                        r_fig    <= n_fig;
                        r_state  <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_state <= r_emit ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= w_out_free ? S_IDLE : S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.last_sample) |=> (r_row == '0 && r_col == '0 && r_fig == '0))
        else $error("counters not cleared after last sample");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_emit_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW && r_emit) |=> (r_state == S_DIV))
        else $error("closing beat did not start a divide");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DIV || $past(r_state) == S_OUT))
        else $error("result beat raised without a finished divide");

endmodule

### sim/frame_group_averager_unit_tb.sv
`timescale 1ns / 1ps

module frame_group_averager_unit_tb;

    localparam int SAMPLE_W     = fga_pkg::SAMPLE_W;
    localparam int CFG_W        = fga_pkg::CFG_W;
    localparam int GRID         = 64;       // pixel store is GRID x GRID
    localparam int DRAIN_CYCLES = 40;       // covers the divide path with margin
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_BEATS = 450;

    // ------------------------------------------------------------------
    // DUT ports; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    fga_pkg::t_in_beat  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    fga_pkg::t_out_beat o_out_data;
    logic               i_cfg_we = 1'b0;
    fga_pkg::t_cfg_idx  i_cfg_idx = fga_pkg::CFG_GROUP_SIZE;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    frame_group_averager_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    fga_pkg::t_in_beat  pending_samples[$];    // beats waiting for the driver
    fga_pkg::t_out_beat pending_means[$];      // predicted results, oldest first
    int          sender_gap_pct = 27;
    int          receiver_gap_pct = 54;
    int          backpressure_left = 0; // long output hold-off, counted by the monitor
    int          fault_count = 0;
    int          cycle_count = 0;

    // Predictor copy of the register file and the block state.
    // Raw register values are kept; the clamp applies at use.
    logic [CFG_W-1:0] cfg_group = 7'd1;
    logic [CFG_W-1:0] cfg_rows  = 7'd64;
    logic [CFG_W-1:0] cfg_cols  = 7'd64;
    longint      pixel_acc[GRID*GRID];
    int          col_pos = 0;
    int          row_pos = 0;
    int          frame_pos = 0;

    // 0 acts as 1, anything past 64 acts as 64 (same rule for all three registers)
    function automatic int clamp_setting(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > 7'd64) return 64;
        return int'(v);
    endfunction

    // Accumulate one pixel and, on the closing frame of a group, queue its mean.
    function automatic void predict_mean(input fga_pkg::t_in_beat beat);
        int                 gsz;
        int                 nrows;
        int                 ncols;
        int                 r;
        int                 c;
        int                 addr;
        longint             acc;
        longint             quo;
        fga_pkg::t_out_beat res;
        gsz   = clamp_setting(cfg_group);
        nrows = clamp_setting(cfg_rows);
        ncols = clamp_setting(cfg_cols);
        // a counter left past a shrunk limit restarts at zero
        r = (row_pos < nrows) ? row_pos : 0;
        c = (col_pos < ncols) ? col_pos : 0;
        addr = r * GRID + c;
        acc = (frame_pos == 0) ? longint'(beat.sample) : pixel_acc[addr] + longint'(beat.sample);
        pixel_acc[addr] = acc;
        // closes on group_size-1 or later: a group shrunk mid-way closes at once
        if (frame_pos + 1 >= gsz) begin
            quo = acc / longint'(gsz);
            if (quo > 32767) quo = 32767;
            if (quo < -32768) quo = -32768;
            res.mean_value   = quo[SAMPLE_W-1:0];
            res.end_of_frame = (r + 1 == nrows) && (c + 1 == ncols);
            pending_means.push_back(res);
        end
        if (beat.last_sample) begin
            // end of volume: a partial trailing group is dropped
            col_pos = 0;
            row_pos = 0;
            frame_pos = 0;
        end else begin
            col_pos = c + 1;
            row_pos = r;
            if (col_pos >= ncols) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= nrows) begin
                    row_pos = 0;
                    frame_pos = (frame_pos + 1 >= gsz) ? 0 : frame_pos + 1;
                end
            end
        end
    endfunction

    // Mostly full-range values, with the rails and values near zero pulled in often.
    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic offer(input logic signed [SAMPLE_W-1:0] s, input logic last);
        pending_samples.push_back('{sample: s, last_sample: last});
    endtask

    // Block is idle once every queued beat went in and every predicted mean came out;
    // beats that close no group may still be in flight, hence the extra pause.
    task automatic settle();
        while (pending_samples.size() != 0 || i_in_valid || pending_means.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write all three registers while idle. A frame that grows in mid volume would
    // make later frames of the group read pixels with no sum of this group, so the
    // volume is closed first in that case.
    task automatic reconfigure(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] r,
                               input logic [CFG_W-1:0] c);
        settle();
        if ((col_pos != 0 || row_pos != 0 || frame_pos != 0) &&
            (clamp_setting(r) > clamp_setting(cfg_rows) ||
             clamp_setting(c) > clamp_setting(cfg_cols))) begin
            offer(draw_sample(), 1'b1);
            settle();
        end
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= fga_pkg::CFG_GROUP_SIZE;
        i_cfg_data <= g;
        @(posedge i_clk);
        cfg_group   = g;
        i_cfg_idx  <= fga_pkg::CFG_FRAME_ROWS;
        i_cfg_data <= r;
        @(posedge i_clk);
        cfg_rows    = r;
        i_cfg_idx  <= fga_pkg::CFG_FRAME_COLS;
        i_cfg_data <= c;
        @(posedge i_clk);
        cfg_cols    = c;
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: presents queued beats, predicts on each accepted beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                predict_mean(i_in_data);
            // load a new beat only when the slot is empty or just went in;
            // a stalled beat stays put
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
                    i_in_data  <= pending_samples.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: checks accepted beats, drives the stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        fga_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_means.size() == 0) begin
                    $error("unexpected beat: mean_value %0d end_of_frame %0b",
                           o_out_data.mean_value, o_out_data.end_of_frame);
                    fault_count++;
                end else begin
                    want = pending_means.pop_front();
                    if (o_out_data.mean_value !== want.mean_value) begin
                        $error("mean_value: expected %0d, got %0d",
                               want.mean_value, o_out_data.mean_value);
                        fault_count++;
                    end
                    if (o_out_data.end_of_frame !== want.end_of_frame) begin
                        $error("end_of_frame: expected %0b, got %0b",
                               want.end_of_frame, o_out_data.end_of_frame);
                        fault_count++;
                    end
                end
            end
            if (backpressure_left > 0) begin
                backpressure_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < receiver_gap_pct);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int               sample_count;
        int               span;
        int               beats;
        logic             close_volume;
        logic [CFG_W-1:0] g;
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] c;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed ---
        // reset settings pass samples through; volume cut short
        offer(16'sh7fff, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'shffff, 1'b1);
        // group 0 acts as 1; end of frame on a 1x2 frame
        reconfigure(7'd0, 7'd1, 7'd2);
        offer(16'sd5, 1'b0);
        offer(-16'sd7, 1'b1);
        // -4/3 truncates toward zero to -1
        reconfigure(7'd3, 7'd1, 7'd1);
        offer(-16'sd1, 1'b0);
        offer(-16'sd1, 1'b0);
        offer(-16'sd2, 1'b1);
        // group shrunk mid group: four-frame sum over one, saturates high then low
        reconfigure(7'd4, 7'd1, 7'd1);
        repeat (3) offer(16'sh7fff, 1'b0);
        reconfigure(7'd1, 7'd1, 7'd1);
        offer(16'sh7fff, 1'b0);
        reconfigure(7'd4, 7'd1, 7'd1);
        repeat (3) offer(16'sh8000, 1'b0);
        reconfigure(7'd1, 7'd1, 7'd1);
        offer(16'sh8000, 1'b1);
        // frame shrunk mid frame: row counter sits past the new limit and wraps
        reconfigure(7'd1, 7'd3, 7'd3);
        repeat (4) offer(draw_sample(), 1'b0);
        reconfigure(7'd1, 7'd1, 7'd2);
        offer(draw_sample(), 1'b0);
        offer(draw_sample(), 1'b1);

        // --- backpressure: output held off while the sender keeps pushing ---
        reconfigure(7'd1, 7'd2, 7'd4);
        sender_gap_pct = 0;
        backpressure_left = 400;
        repeat (40) offer(draw_sample(), 1'b0);
        sample_count = 40;

        // --- random volumes ---
        while (sample_count < RANDOM_BEATS) begin
            if (sample_count >= 300) begin
                sender_gap_pct = 0;
                receiver_gap_pct = 0;
            end else if (sample_count >= 150) begin
                sender_gap_pct = 54;
                receiver_gap_pct = 27;
            end else begin
                sender_gap_pct = 27;
                receiver_gap_pct = 54;
            end

            // mostly small frames; the large shapes keep the beat count per group bounded
            case ($urandom_range(0, 9))
                0: begin
                    g = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(5, 127));
                    r = 7'($urandom_range(0, 1));
                    c = 7'($urandom_range(0, 2));
                end
                1: begin
                    g = 7'($urandom_range(0, 2));
                    r = ($urandom_range(0, 2) == 0) ? 7'd64 : 7'($urandom_range(60, 127));
                    c = 7'($urandom_range(0, 1));
                end
                2: begin
                    g = 7'($urandom_range(0, 2));
                    r = 7'($urandom_range(0, 1));
                    c = ($urandom_range(0, 2) == 0) ? 7'd64 : 7'($urandom_range(60, 127));
                end
                default: begin
                    g = 7'($urandom_range(0, 4));
                    r = 7'($urandom_range(0, 4));
                    c = 7'($urandom_range(0, 5));
                end
            endcase
            // now and then keep the settings so volumes run back to back
            if ($urandom_range(0, 3) != 0)
                reconfigure(g, r, c);

            span  = clamp_setting(cfg_group) * clamp_setting(cfg_rows) * clamp_setting(cfg_cols);
            beats = span * $urandom_range(1, 3);
            if (beats > 200) beats = span;
            case ($urandom_range(0, 4))
                0: beats += $urandom_range(0, span - 1);   // partial trailing group
                1: beats = $urandom_range(1, beats);       // volume broken off early
                default: ;
            endcase
            // an open volume lets the next settings land mid volume
            close_volume = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < beats; k++)
                offer(draw_sample(),
                      (k == beats - 1 && close_volume) || $urandom_range(0, 59) == 0);
            sample_count += beats;
        end

        settle();
        if (fault_count == 0 && pending_means.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
